// File: rtl/core/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the framed reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

  // Default message store depth in bytes
  localparam int unsigned BUF_BYTES_DEF = 32;

  // Message lengths of the widest supported store (up to 256 bytes) fit here
  localparam int unsigned MSG_LEN_W = 8;

  // Output field widths
  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned OUT_LEN_W = 5;

  // Frame header bytes kept in the store (command, length low, length high)
  localparam int unsigned HDR_BYTES = 3;
  // Store bytes reserved beyond the largest accepted payload
  localparam int unsigned FRAME_OVH = 10;

  // Byte codes
  localparam logic [7:0] START_BYTE = 8'h50;
  localparam logic [7:0] NACK_BYTE  = 8'h01;
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] CARRIAGE   = 8'h0D;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_R     = 8'h52;

  // Status and kind codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NACK = 1'b1;
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // Protocol mode codes
  localparam logic MODE_TEXT   = 1'b0;
  localparam logic MODE_FRAMED = 1'b1;

  // Front-end parser phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  // Completed message handed from front to back
  typedef struct packed {
    logic [MSG_LEN_W-1:0] len;     // stored bytes to read out
    logic                 empty;   // line that was only a CR: one zero result
    logic                 status;
    logic                 kind;
  } msg_desc_t;

endpackage

`default_nettype wire

// File: rtl/core/frp_store.sv
// ----------------------------------------------------------------------------
// frp_store
// Message byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_store #(
  parameter int unsigned BUF_BYTES = frp_pkg::BUF_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUF_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/frp_front.sv
// ----------------------------------------------------------------------------
// frp_front
// Byte parser: classifies each received byte as text or frame content,
// writes the store and posts a descriptor when a message completes.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_front #(
  parameter int unsigned BUF_BYTES = frp_pkg::BUF_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUF_BYTES)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_wr_en_i,
  input  wire logic                 cfg_wr_data_i,
  // received bytes
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           in_byte_i,
  // back end status
  input  wire logic                 back_busy_i,
  // store write port
  output logic                      we_o,
  output logic      [AW-1:0]        waddr_o,
  output logic      [7:0]           wdata_o,
  // descriptor slot
  output logic                      desc_valid_o,
  input  wire logic                 desc_ready_i,
  output frp_pkg::msg_desc_t        desc_o
);

  frp_pkg::phase_e    phase_q, phase_d;
  logic               mode_q, mode_d;
  logic [AW-1:0]      fill_q, fill_d;
  logic [AW-1:0]      exp_q, exp_d;
  logic [7:0]         len_lo_q, len_lo_d;
  logic               e0_q, e0_d, r1_q, r1_d, r2_q, r2_d;
  logic               last_cr_q, last_cr_d;
  logic               nack_q, nack_d;
  logic               desc_v_q, desc_v_d;
  frp_pkg::msg_desc_t desc_q, desc_d;

  logic               accept;
  logic [15:0]        exp_full;
  logic [AW-1:0]      text_len;
  logic               pay_done;

  // One byte per transfer; hold off while a message waits or drains
  assign in_ready_o = !desc_v_q && !back_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  assign exp_full = {in_byte_i, len_lo_q};
  assign text_len = fill_q - AW'(last_cr_q);
  assign pay_done = (fill_q + AW'(1)) == exp_q;

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= frp_pkg::PH_IDLE;
      mode_q   <= frp_pkg::MODE_TEXT;
      fill_q   <= '0;
      desc_v_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      fill_q   <= fill_d;
      desc_v_q <= desc_v_d;
    end
  end

  // Header and flag payload registers
  always_ff @(posedge clk_i) begin
    exp_q     <= exp_d;
    len_lo_q  <= len_lo_d;
    e0_q      <= e0_d;
    r1_q      <= r1_d;
    r2_q      <= r2_d;
    last_cr_q <= last_cr_d;
    nack_q    <= nack_d;
    desc_q    <= desc_d;
  end

  // Next state, store writes and descriptor
  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    fill_d    = fill_q;
    exp_d     = exp_q;
    len_lo_d  = len_lo_q;
    e0_d      = e0_q;
    r1_d      = r1_q;
    r2_d      = r2_q;
    last_cr_d = last_cr_q;
    nack_d    = nack_q;
    desc_d    = desc_q;
    desc_v_d  = desc_v_q && !desc_ready_i;
    we_o      = 1'b0;
    waddr_o   = fill_q;
    wdata_o   = in_byte_i;

    if (cfg_wr_en_i) begin
      mode_d  = cfg_wr_data_i;
      phase_d = frp_pkg::PH_IDLE;
      fill_d  = '0;
    end else if (accept) begin
      case (phase_q)
        frp_pkg::PH_CMD: begin
          we_o    = mode_q;
          waddr_o = AW'(0);
          phase_d = mode_q ? frp_pkg::PH_LEN_LO : frp_pkg::PH_IDLE;
        end
        frp_pkg::PH_LEN_LO: begin
          we_o     = mode_q;
          waddr_o  = AW'(1);
          len_lo_d = in_byte_i;
          phase_d  = mode_q ? frp_pkg::PH_LEN_HI : frp_pkg::PH_IDLE;
        end
        frp_pkg::PH_LEN_HI: begin
          we_o    = mode_q;
          waddr_o = AW'(2);
          fill_d  = '0;
          phase_d = frp_pkg::PH_IDLE;
          if (!mode_q) begin
            we_o = 1'b0;
          end else if (exp_full > 16'(BUF_BYTES - frp_pkg::FRAME_OVH)) begin
            // oversized: drop the frame
            phase_d = frp_pkg::PH_IDLE;
          end else if (exp_full == 16'd0) begin
            // header only
            desc_v_d     = 1'b1;
            desc_d.len   = frp_pkg::MSG_LEN_W'(frp_pkg::HDR_BYTES);
            desc_d.empty = 1'b0;
            desc_d.status = frp_pkg::STATUS_OK;
            desc_d.kind  = frp_pkg::KIND_FRAME;
          end else begin
            exp_d   = exp_full[AW-1:0];
            phase_d = frp_pkg::PH_PAYLOAD;
          end
        end
        frp_pkg::PH_PAYLOAD: begin
          we_o    = mode_q;
          waddr_o = fill_q + AW'(frp_pkg::HDR_BYTES);
          phase_d = frp_pkg::PH_IDLE;
          if (mode_q) begin
            if (fill_q == '0) begin
              nack_d = (in_byte_i == frp_pkg::NACK_BYTE);
            end
            if (pay_done) begin
              desc_v_d     = 1'b1;
              desc_d.len   = frp_pkg::MSG_LEN_W'(frp_pkg::HDR_BYTES)
                             + frp_pkg::MSG_LEN_W'(exp_q);
              desc_d.empty = 1'b0;
              desc_d.status = (fill_q == '0) ? (in_byte_i == frp_pkg::NACK_BYTE)
                                             : nack_q;
              desc_d.kind  = frp_pkg::KIND_FRAME;
              fill_d       = '0;
            end else begin
              fill_d  = fill_q + AW'(1);
              phase_d = frp_pkg::PH_PAYLOAD;
            end
          end
        end
        default: begin
          phase_d = frp_pkg::PH_IDLE;
          if ((mode_q == frp_pkg::MODE_FRAMED) && (in_byte_i == frp_pkg::START_BYTE)) begin
            // start of a frame, any partial line is discarded
            phase_d = frp_pkg::PH_CMD;
            fill_d  = '0;
          end else if (in_byte_i == frp_pkg::LINE_FEED) begin
            if (fill_q != '0) begin
              desc_v_d      = 1'b1;
              desc_d.len    = frp_pkg::MSG_LEN_W'(text_len);
              desc_d.empty  = (text_len == '0);
              desc_d.status = (text_len >= AW'(3)) && e0_q && r1_q && r2_q;
              desc_d.kind   = frp_pkg::KIND_TEXT;
              fill_d        = '0;
            end
          end else if (fill_q < AW'(BUF_BYTES - 1)) begin
            we_o      = 1'b1;
            fill_d    = fill_q + AW'(1);
            last_cr_d = (in_byte_i == frp_pkg::CARRIAGE);
            if (fill_q == AW'(0)) e0_d = (in_byte_i == frp_pkg::CHAR_E);
            if (fill_q == AW'(1)) r1_d = (in_byte_i == frp_pkg::CHAR_R);
            if (fill_q == AW'(2)) r2_d = (in_byte_i == frp_pkg::CHAR_R);
          end
        end
      endcase
    end
  end

  assign desc_valid_o = desc_v_q;
  assign desc_o       = desc_q;

endmodule

`default_nettype wire

// File: rtl/core/frp_back.sv
// ----------------------------------------------------------------------------
// frp_back
// Drain engine: reads a completed message out of the store and presents
// one result per byte through a read stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_back #(
  parameter int unsigned BUF_BYTES = frp_pkg::BUF_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUF_BYTES)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // descriptor from the front end
  input  wire logic                              desc_valid_i,
  output logic                                   desc_ready_o,
  input  wire frp_pkg::msg_desc_t                desc_i,
  output logic                                   busy_o,
  // store read port
  output logic                                   re_o,
  output logic      [AW-1:0]                     raddr_o,
  input  wire logic [7:0]                        rdata_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_status_o,
  output logic                                   out_kind_o,
  output logic      [7:0]                        out_byte_o,
  output logic      [frp_pkg::OUT_IDX_W-1:0]     out_idx_o,
  output logic      [frp_pkg::OUT_LEN_W-1:0]     out_len_o,
  output logic                                   out_last_o
);

  localparam int unsigned LW = frp_pkg::MSG_LEN_W;

  // Read sequencer
  logic          act_q;
  logic [LW-1:0] k_q, len_q;
  logic          status_q, kind_q, empty_q;

  // Read data stage
  logic                          s1_v_q;
  logic [frp_pkg::OUT_IDX_W-1:0] s1_idx_q;
  logic [frp_pkg::OUT_LEN_W-1:0] s1_len_q;
  logic                          s1_last_q, s1_zero_q, s1_status_q, s1_kind_q;

  // Output register
  logic                          out_v_q;
  logic [7:0]                    out_byte_q;
  logic [frp_pkg::OUT_IDX_W-1:0] out_idx_q;
  logic [frp_pkg::OUT_LEN_W-1:0] out_len_q;
  logic                          out_last_q, out_status_q, out_kind_q;

  logic issue, s1_adv, load, issue_last;

  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign issue      = act_q && (!s1_v_q || s1_adv);
  assign issue_last = empty_q || ((k_q + LW'(1)) == len_q);
  assign load       = desc_valid_i && !act_q;

  assign desc_ready_o = !act_q;
  assign busy_o       = act_q;
  assign re_o         = issue && !empty_q;
  assign raddr_o      = k_q[AW-1:0];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
      end else if (issue && issue_last) begin
        act_q <= 1'b0;
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Message being drained
  always_ff @(posedge clk_i) begin
    if (load) begin
      k_q      <= '0;
      len_q    <= desc_i.len;
      status_q <= desc_i.status;
      kind_q   <= desc_i.kind;
      empty_q  <= desc_i.empty;
    end else if (issue) begin
      k_q <= k_q + LW'(1);
    end
  end

  // Read data stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q    <= k_q[frp_pkg::OUT_IDX_W-1:0];
      s1_len_q    <= len_q[frp_pkg::OUT_LEN_W-1:0];
      s1_last_q   <= issue_last;
      s1_zero_q   <= empty_q;
      s1_status_q <= status_q;
      s1_kind_q   <= kind_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q   <= s1_zero_q ? 8'd0 : rdata_i;
      out_idx_q    <= s1_idx_q;
      out_len_q    <= s1_len_q;
      out_last_q   <= s1_last_q;
      out_status_q <= s1_status_q;
      out_kind_q   <= s1_kind_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_status_o = out_status_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign out_idx_o    = out_idx_q;
  assign out_len_o    = out_len_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/framed_reply_parser_top.sv
// ----------------------------------------------------------------------------
// framed_reply_parser_top
// Assembles text lines or length-prefixed binary frames from received bytes
// and streams each completed message out one stored byte per transfer.
// ----------------------------------------------------------------------------
// When a byte completes a message (line feed, or the last payload byte of a
// frame) the message is read out of the single-port-read byte store at one
// result per cycle while the output does not stall: a message of N bytes gives
// N results, and an empty line (only a CR) gives one. The input holds tready
// low from completion until the last byte has been read from the store, since
// the next message reuses the store; the final result may still wait in the
// output register while new bytes are taken. No clearing pass follows reset.
`default_nettype none

module framed_reply_parser_top #(
  parameter int unsigned BUF_BYTES = frp_pkg::BUF_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: protocol_mode
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_wr_data_i,
  // received bytes
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // results
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o,   // [7:0] message_byte, [12:8] byte_index,
                                             // [17:13] message_length, [23:18] zero
  output logic      [1:0]  m_axis_tuser_o,   // [0] reply_status, [1] message_kind
  output logic             m_axis_tlast_o    // last_of_message
);

  localparam int unsigned AW = $clog2(BUF_BYTES);

  logic               back_busy;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;
  logic               desc_valid;
  logic               desc_ready;
  frp_pkg::msg_desc_t desc;

  logic [7:0]                        out_byte;
  logic [frp_pkg::OUT_IDX_W-1:0]     out_idx;
  logic [frp_pkg::OUT_LEN_W-1:0]     out_len;
  logic                              out_status;
  logic                              out_kind;

  // Parser front end
  frp_front #(
    .BUF_BYTES(BUF_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_byte_i     (s_axis_tdata_i),
    .back_busy_i   (back_busy),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .desc_valid_o  (desc_valid),
    .desc_ready_i  (desc_ready),
    .desc_o        (desc)
  );

  // Message byte store
  frp_store #(
    .BUF_BYTES(BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Drain back end
  frp_back #(
    .BUF_BYTES(BUF_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_i       (desc),
    .busy_o       (back_busy),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .out_idx_o    (out_idx),
    .out_len_o    (out_len),
    .out_last_o   (m_axis_tlast_o)
  );

  // Result packing
  assign m_axis_tdata_o = {6'd0, out_len, out_idx, out_byte};
  assign m_axis_tuser_o = {out_kind, out_status};

`ifndef SYNTHESIS
  // No byte may be taken while the store is being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> !s_axis_tready_o)
    else $error("input accepted during message drain");

  // A pending descriptor blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid |-> !s_axis_tready_o)
    else $error("input accepted with a message pending");

  // The final result of a run sits at the end of the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      ((out_len == '0 && out_idx == '0) ||
       (frp_pkg::OUT_LEN_W'(out_idx + frp_pkg::OUT_IDX_W'(1)) == out_len)))
    else $error("last result does not match message length");

  // Reads are only issued while a message is draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> back_busy)
    else $error("store read outside a drain");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for framed_reply_parser_top. Received bytes are driven
// into the input stream as text lines, binary frames and noise, in both
// protocol modes. A scoreboard predicts each reply run and checks every
// result transfer field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import frp_pkg::*;

  localparam int unsigned STORE_BYTES   = BUF_BYTES_DEF;
  localparam int unsigned MAX_PAYLOAD   = STORE_BYTES - FRAME_OVH;
  localparam int unsigned RX_TARGET     = 140;   // received bytes to reach before the random phases stop
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned STUCK_LIMIT   = 1000;

  // One result transfer as seen on the output stream
  typedef struct packed {
    logic       status;
    logic       kind;
    logic [7:0] data;
    logic [4:0] idx;
    logic [4:0] mlen;
    logic       last;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks parser state and holds the reply runs still due
  // --------------------------------------------------------------------------
  class reply_scoreboard;
    logic        mode;
    phase_e      phase;
    int unsigned fill;
    int unsigned frame_len;
    logic [7:0]  store [STORE_BYTES];
    reply_t      replies_due [$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned replies_seen;
    int unsigned lines_done;
    int unsigned frames_done;
    int unsigned frames_dropped;
    int unsigned nacks;
    int unsigned mode_writes;

    function new();
      mode = MODE_TEXT;
      phase = PH_IDLE;
    endfunction

    // Mode write also resets the parser
    function void set_mode(logic m);
      mode = m;
      phase = PH_IDLE;
      fill = 0;
      frame_len = 0;
      mode_writes++;
    endfunction

    // Queue the reply run of a completed message; n == 0 is the CR-only line
    function void queue_run(int unsigned n, logic st, logic kd);
      reply_t r;
      r.status = st;
      r.kind = kd;
      if (st == STATUS_NACK) nacks++;
      if (n == 0) begin
        r.data = 8'h00;
        r.idx = '0;
        r.mlen = '0;
        r.last = 1'b1;
        replies_due.push_back(r);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        r.data = store[k];
        r.idx = k[4:0];
        r.mlen = n[4:0];
        r.last = (k + 1 == n);
        replies_due.push_back(r);
      end
    endfunction

    // Text line assembly; one trailing CR is stripped, ERR prefix means NACK
    function void text_char(logic [7:0] c);
      int unsigned n;
      logic st;
      if (c == LINE_FEED) begin
        n = fill;
        if (n == 0) return;
        if (store[n-1] == CARRIAGE) n--;
        st = (n >= 3 && store[0] == CHAR_E && store[1] == CHAR_R && store[2] == CHAR_R)
             ? STATUS_NACK : STATUS_OK;
        fill = 0;
        lines_done++;
        queue_run(n, st, KIND_TEXT);
        return;
      end
      // bytes past the store are dropped
      if (fill < STORE_BYTES - 1) begin
        store[fill] = c;
        fill++;
      end
    endfunction

    // Note one accepted received byte
    function void parse_rx_byte(logic [7:0] c);
      logic st;
      bytes_seen++;
      if (mode == MODE_TEXT) begin
        phase = PH_IDLE;
        text_char(c);
        return;
      end
      case (phase)
        PH_CMD: begin
          store[0] = c;
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          store[1] = c;
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          store[2] = c;
          frame_len = 32'({c, store[1]});
          if (frame_len > MAX_PAYLOAD) begin
            // oversized: frame dropped silently
            frames_dropped++;
            phase = PH_IDLE;
            fill = 0;
            frame_len = 0;
          end else begin
            fill = 0;
            if (frame_len == 0) begin
              phase = PH_IDLE;
              frames_done++;
              queue_run(HDR_BYTES, STATUS_OK, KIND_FRAME);
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (fill + HDR_BYTES < STORE_BYTES) store[fill + HDR_BYTES] = c;
          fill++;
          if (fill >= frame_len) begin
            st = (store[HDR_BYTES] == NACK_BYTE) ? STATUS_NACK : STATUS_OK;
            phase = PH_IDLE;
            fill = 0;
            frames_done++;
            queue_run(HDR_BYTES + frame_len, st, KIND_FRAME);
          end
        end
        default: begin
          // start byte while idle drops any partial line and opens a frame
          phase = PH_IDLE;
          if (c == START_BYTE) begin
            phase = PH_CMD;
            fill = 0;
            frame_len = 0;
          end else begin
            text_char(c);
          end
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result transfer against the oldest reply due
    function void check_reply(logic [23:0] tdata, logic [1:0] tuser, logic tlast);
      reply_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got tdata %06h tuser %0h tlast %0b",
                 $time, tdata, tuser, tlast);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      cmp_field("message_byte",    want.data,       tdata[7:0]);
      cmp_field("byte_index",      8'(want.idx),    8'(tdata[12:8]));
      cmp_field("message_length",  8'(want.mlen),   8'(tdata[17:13]));
      cmp_field("tdata padding",   8'h00,           8'(tdata[23:18]));
      cmp_field("reply_status",    8'(want.status), 8'(tuser[0]));
      cmp_field("message_kind",    8'(want.kind),   8'(tuser[1]));
      cmp_field("last_of_message", 8'(want.last),   8'(tlast));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_en = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  wire logic        s_axis_tready_o;
  wire logic        m_axis_tvalid_o;
  wire logic [23:0] m_axis_tdata_o;
  wire logic [1:0]  m_axis_tuser_o;
  wire logic        m_axis_tlast_o;

  reply_scoreboard sb;
  logic [7:0]      rx_q [$];
  bit              no_gaps = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     stuck_cycles = 0;

  always #5 clk = ~clk;

  framed_reply_parser_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_en),
    .cfg_wr_data_i   (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output side: check accepted transfers, stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_ready)
        sb.check_reply(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      if (stall_left != 0) begin
        m_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles, %0d replies still due",
               $time, STUCK_LIMIT, sb.replies_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk); while (!s_axis_tready_o);
    sb.parse_rx_byte(b);
    gap = pick_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_queued();
    while (rx_q.size() != 0) send_byte(rx_q.pop_front());
    s_valid <= 1'b0;
  endtask

  task automatic write_mode(input logic m);
    cfg_en <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_en <= 1'b0;
    sb.set_mode(m);
  endtask

  // Send what is queued, let every reply drain, settle, then switch mode
  task automatic end_phase(input logic next_mode);
    send_queued();
    while (sb.replies_due.size() != 0) @(posedge clk);
    no_gaps = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_mode(next_mode);
  endtask

  // --------------------------------------------------------------------------
  // Message builders
  // --------------------------------------------------------------------------
  function automatic logic [7:0] text_char_rand();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == LINE_FEED || (sb.mode == MODE_FRAMED && b == START_BYTE));
    return b;
  endfunction

  // prefix: 1 puts ERR in front, 2 puts the near miss ER
  function automatic void add_text_line(int unsigned len, bit with_cr, int unsigned prefix);
    if (prefix == 1) begin
      rx_q.push_back(CHAR_E);
      rx_q.push_back(CHAR_R);
      rx_q.push_back(CHAR_R);
    end else if (prefix == 2) begin
      rx_q.push_back(CHAR_E);
      rx_q.push_back(CHAR_R);
    end
    repeat (len) rx_q.push_back(text_char_rand());
    if (with_cr) rx_q.push_back(CARRIAGE);
    rx_q.push_back(LINE_FEED);
  endfunction

  function automatic void add_frame(int unsigned plen, bit nack);
    rx_q.push_back(START_BYTE);
    rx_q.push_back(8'($urandom_range(0, 255)));
    rx_q.push_back(plen[7:0]);
    rx_q.push_back(8'h00);
    for (int unsigned k = 0; k < plen; k++)
      rx_q.push_back((k == 0 && nack) ? NACK_BYTE : 8'($urandom_range(0, 255)));
  endfunction

  // Length above the store limit, by the low byte or by the high byte
  function automatic void add_big_frame();
    rx_q.push_back(START_BYTE);
    rx_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) begin
      rx_q.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      rx_q.push_back(8'h00);
    end else begin
      rx_q.push_back(8'($urandom_range(0, 255)));
      rx_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void add_noise(int unsigned n);
    repeat (n) rx_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned line_len_rand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 8);
    if (r < 90) return $urandom_range(9, 30);
    return $urandom_range(31, 40);
  endfunction

  function automatic int unsigned prefix_rand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 1;
    if (r < 35) return 2;
    return 0;
  endfunction

  function automatic int unsigned payload_len_rand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 65) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, MAX_PAYLOAD - 1);
    return MAX_PAYLOAD;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned n_msgs;
    bit          first_random;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_TEXT);

    // Text mode: ERR line with trailing CR, CR-only line, bare newline,
    // start byte as plain text next to the byte extremes
    rx_q = '{CHAR_E, CHAR_R, CHAR_R, CARRIAGE, LINE_FEED,
             CARRIAGE, LINE_FEED,
             LINE_FEED,
             START_BYTE, 8'hFF, 8'h00, LINE_FEED};
    end_phase(MODE_FRAMED);

    // Framed mode: start byte mid-line with an empty frame, NACK frame,
    // oversized frame
    rx_q = '{8'h61, START_BYTE, 8'hA5, 8'h00, 8'h00,
             START_BYTE, 8'h7E, 8'h01, 8'h00, NACK_BYTE,
             START_BYTE, 8'h11, 8'(MAX_PAYLOAD + 1), 8'h00};
    end_phase(MODE_TEXT);

    // Random phases, each in one mode; partial messages may be left open
    first_random = 1'b1;
    while (sb.bytes_seen < RX_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (first_random) add_text_line(36, 1'b1, 1);   // overflowing ERR line
      first_random = 1'b0;
      n_msgs = $urandom_range(4, 8);
      repeat (n_msgs) begin
        r = $urandom_range(0, 99);
        if (sb.mode == MODE_TEXT) begin
          if (r < 85) add_text_line(line_len_rand(), 1'($urandom_range(0, 1)), prefix_rand());
          else add_noise($urandom_range(1, 4));
        end else begin
          if (r < 45) add_frame(payload_len_rand(), $urandom_range(0, 99) < 30);
          else if (r < 55) add_big_frame();
          else if (r < 88)
            add_text_line(line_len_rand(), 1'($urandom_range(0, 1)), prefix_rand());
          else add_noise($urandom_range(1, 4));
        end
      end
      end_phase(1'($urandom_range(0, 1)));
    end

    // Drain and finish
    send_queued();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d received bytes over %0d mode writes: %0d text lines, %0d frames,",
             sb.bytes_seen, sb.mode_writes, sb.lines_done, sb.frames_done);
    $display("%0d oversized frames dropped; checked %0d result transfers, %0d NACK replies",
             sb.frames_dropped, sb.replies_seen, sb.nacks);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
